// ----- hw/rtl/reward_driven_perceptron_macros.svh -----
// Assertion macros shared by the checker of the reward driven perceptron.
// Depends on nothing; each macro expects i_clk and i_rst_n in scope.
`ifndef REWARD_DRIVEN_PERCEPTRON_MACROS_SVH
`define REWARD_DRIVEN_PERCEPTRON_MACROS_SVH

// same-cycle implication, disabled during reset
`define RDP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rdp: same-cycle check failed");

// next-cycle implication, disabled during reset
`define RDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rdp: next-cycle check failed");

`endif

// ----- hw/rtl/rdp_pkg.sv -----
// Package for the reward driven perceptron: mode codes, widths, fixed-point constants.
// Depends on nothing.
package rdp_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 32;
    localparam int MARK_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int FACTOR_W = 16;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 56;

    // 1.0 in Q8.8
    localparam logic signed [SAMPLE_W-1:0] BIAS_ONE = 16'sd256;

    typedef enum logic [1:0] {
        MODE_EVAL  = 2'd0,
        MODE_LEARN = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic {
        CFG_LEARN_FACTOR = 1'b0,
        CFG_ATTEMPTS     = 1'b1
    } t_cfg_index;

endpackage

// ----- hw/rtl/reward_driven_perceptron.sv -----
// Reward driven single neuron: bias plus two Q8.8 samples, Q8.24 saturating weights.
// Depends on rdp_pkg.
//
//  channel  | dir | handshake            | payload
//  s (item) | in  | i_s_tvalid/o_s_tready| tuser mode, tdata samples and mark
//  m (res)  | out | o_m_tvalid/i_m_tready| tdata out/attempts/best, tlast round_done
//  cfg      | in  | i_cfg_valid/o_cfg_ready | index, 16-bit data
//
// One item per cycle while the output is not stalled: the request is registered,
// then evaluated or learned into the result register, which drives o_m_tvalid.
// The rate is set by the combinational state update (three products and the sum).
// Synchronous active-low reset clears all but payloads; both registers drain on reset.
// An output stall holds the result; the input register then fills and drops o_s_tready.
module reward_driven_perceptron (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [rdp_pkg::IN_DATA_W-1:0]   i_s_tdata,  // sample_a, sample_b, reward_mark
    input  logic [1:0]                      i_s_tuser,  // mode
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [rdp_pkg::OUT_DATA_W-1:0]  o_m_tdata,  // neuron_out, attempts_remaining, best_mark
    output logic                            o_m_tlast,  // round_done
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);
    import rdp_pkg::*;

    // input register
    logic                        r_in_valid;
    t_mode                       r_in_mode;
    logic signed [SAMPLE_W-1:0]  r_in_sa;
    logic signed [SAMPLE_W-1:0]  r_in_sb;
    logic signed [MARK_W-1:0]    r_in_mark;

    // result register
    logic                        r_out_valid;
    logic                        r_out_bit;
    logic                        r_out_done;
    logic [COUNT_W-1:0]          r_out_cnt;
    logic signed [MARK_W-1:0]    r_out_best;

    // neuron state
    logic [FACTOR_W-1:0]         r_factor;
    logic [COUNT_W-1:0]          r_attempts;
    logic signed [WEIGHT_W-1:0]  r_w [3];
    logic signed [SAMPLE_W-1:0]  r_smp [2];
    logic                        r_bit;
    logic signed [MARK_W-1:0]    r_prev;
    logic signed [MARK_W-1:0]    r_top;
    logic [COUNT_W-1:0]          r_cnt;

    logic                        n_bit;
    logic signed [WEIGHT_W-1:0]  n_w [3];
    logic signed [SAMPLE_W-1:0]  n_smp [2];
    logic signed [MARK_W-1:0]    n_prev;
    logic signed [MARK_W-1:0]    n_top;
    logic [COUNT_W-1:0]          n_cnt;
    logic                        n_done;

    logic                        w_fire;
    logic signed [47:0]          w_prod [3];
    logic signed [49:0]          w_sum;
    logic signed [SAMPLE_W-1:0]  w_x [3];
    logic signed [32:0]          w_step [3];
    logic signed [33:0]          w_acc [3];
    logic [COUNT_W-1:0]          w_cnt_dec;

    assign w_fire      = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || w_fire;
    assign o_cfg_ready = 1'b1;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_done;
    assign o_m_tdata  = {7'd0, r_out_best, r_out_cnt, r_out_bit};

    always_comb begin
        w_prod[0] = r_w[0] * BIAS_ONE;
        w_prod[1] = r_w[1] * r_in_sa;
        w_prod[2] = r_w[2] * r_in_sb;
        w_sum = {{2{w_prod[0][47]}}, w_prod[0]} + {{2{w_prod[1][47]}}, w_prod[1]}
              + {{2{w_prod[2][47]}}, w_prod[2]};

        w_x[0] = BIAS_ONE;
        w_x[1] = r_smp[0];
        w_x[2] = r_smp[1];
        for (int i = 0; i < 3; i++) begin
            w_step[i] = w_x[i] * $signed({1'b0, r_factor});
            if (r_bit) begin
                w_acc[i] = {{2{r_w[i][31]}}, r_w[i]} - {w_step[i][32], w_step[i]};
            end else begin
                w_acc[i] = {{2{r_w[i][31]}}, r_w[i]} + {w_step[i][32], w_step[i]};
            end
        end
        w_cnt_dec = (r_cnt != '0) ? r_cnt - 1'b1 : r_cnt;

        n_bit  = r_bit;
        n_w    = r_w;
        n_smp  = r_smp;
        n_prev = r_prev;
        n_top  = r_top;
        n_cnt  = r_cnt;
        n_done = 1'b0;

        case (r_in_mode)
            MODE_EVAL: begin
                n_smp[0] = r_in_sa;
                n_smp[1] = r_in_sb;
                n_bit    = !w_sum[49] && (w_sum != '0);
            end
            MODE_LEARN: begin
                n_cnt = w_cnt_dec;
                if (r_in_mark > r_top) begin
                    n_top = r_in_mark;
                end
                if (!(r_in_mark > r_prev)) begin
                    for (int i = 0; i < 3; i++) begin
                        if (w_acc[i][33:31] == 3'b000 || w_acc[i][33:31] == 3'b111) begin
                            n_w[i] = w_acc[i][31:0];
                        end else if (w_acc[i][33]) begin
                            n_w[i] = {1'b1, {(WEIGHT_W-1){1'b0}}};
                        end else begin
                            n_w[i] = {1'b0, {(WEIGHT_W-1){1'b1}}};
                        end
                    end
                end
                n_prev = r_in_mark;
                if (w_cnt_dec == '0 && r_in_mark >= r_top) begin
                    n_cnt  = r_attempts;
                    n_prev = '0;
                    n_top  = '0;
                    n_done = 1'b1;
                end
            end
            MODE_CLEAR: begin
                for (int i = 0; i < 3; i++) begin
                    n_w[i] = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_mode <= t_mode'(i_s_tuser);
            r_in_sa   <= i_s_tdata[15:0];
            r_in_sb   <= i_s_tdata[31:16];
            r_in_mark <= i_s_tdata[63:32];
        end
        if (w_fire) begin
            r_out_bit  <= n_bit;
            r_out_done <= n_done;
            r_out_cnt  <= n_cnt;
            r_out_best <= n_top;
        end
    end

    // control and neuron state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_factor    <= '0;
            r_attempts  <= '0;
            r_bit       <= 1'b0;
            r_prev      <= '0;
            r_top       <= '0;
            r_cnt       <= '0;
            for (int i = 0; i < 3; i++) begin
                r_w[i] <= '0;
            end
            r_smp[0] <= '0;
            r_smp[1] <= '0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end

            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            if (w_fire) begin
                r_bit  <= n_bit;
                r_w    <= n_w;
                r_smp  <= n_smp;
                r_prev <= n_prev;
                r_top  <= n_top;
            end

            if (i_cfg_valid && t_cfg_index'(i_cfg_index) == CFG_ATTEMPTS) begin
                r_cnt <= i_cfg_data;
            end else if (w_fire) begin
                r_cnt <= n_cnt;
            end

            if (i_cfg_valid) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_LEARN_FACTOR: r_factor <= i_cfg_data;
                    CFG_ATTEMPTS:     r_attempts <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ----- hw/rtl/rdp_checker.sv -----
// Port-level checks for the reward driven perceptron, bound to the top level.
// Depends on rdp_pkg and reward_driven_perceptron_macros.svh.
`include "reward_driven_perceptron_macros.svh"

module rdp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [rdp_pkg::OUT_DATA_W-1:0]  o_m_tdata,  // neuron_out, attempts_remaining, best_mark
    input logic                            o_m_tlast   // round_done
);
    import rdp_pkg::*;

    // a stalled result holds
    `RDP_ASSERT_NEXT(a_stall_hold, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))

    // a finished round clears the best mark
    `RDP_ASSERT_NOW(a_done_clears_best, o_m_tvalid && o_m_tlast, o_m_tdata[48:17] == 32'd0)

    // padding above best_mark stays zero
    `RDP_ASSERT_NOW(a_pad_zero, o_m_tvalid, o_m_tdata[55:49] == 7'd0)

    // nothing leaves right after reset
    `RDP_ASSERT_NOW(a_empty_after_reset, $rose(i_rst_n), !o_m_tvalid)

endmodule

bind reward_driven_perceptron rdp_checker u_rdp_checker (.*);

// ----- test/reward_driven_perceptron_test.sv -----
// Self-checking bench for reward_driven_perceptron: a directed table, then random trial phases,
// checked against an in-bench neuron predictor over random stalls on both streams.
// Depends on rdp_pkg and the reward_driven_perceptron RTL.
module reward_driven_perceptron_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rdp_pkg::*;

    localparam int     IDLE_LIMIT = 500;
    localparam int     REQUESTS   = 1900;
    localparam longint W_MAX      = 2147483647;
    localparam longint W_MIN      = -longint'(2147483647) - 1;

    typedef struct packed {
        logic               fire;
        logic               done;
        logic [15:0]        remaining;
        logic signed [31:0] best;
    } t_result;

    typedef struct {
        logic               is_cfg;
        t_cfg_index         reg_idx;
        logic [15:0]        reg_val;
        t_mode              mode;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [31:0] mark;
        logic               typed;
        t_result            want;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata;   // sample_a, sample_b, reward_mark
    logic [1:0]             i_s_tuser;   // mode
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_DATA_W-1:0]  o_m_tdata;   // neuron_out, attempts_remaining, best_mark, pad
    logic                   o_m_tlast;   // round_done
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic                   i_cfg_index;
    logic [15:0]            i_cfg_data;

    reward_driven_perceptron dut (.*);

    // predictor state
    logic signed [31:0] syn_w [3];
    logic signed [15:0] held_a, held_b;
    logic               fire;
    logic signed [31:0] last_mark, peak_mark;
    logic [15:0]        tries_left, tries_per_round, rate;

    t_result pending_results [$];
    t_row    directed_rows [$];

    bit steady;
    int score;
    int mismatches, results_seen, requests_sent, rounds_done, saturations, settings_used;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic neuron_step(input t_mode m, input logic signed [15:0] a,
                               input logic signed [15:0] b, input logic signed [31:0] mark,
                               output t_result r);
        longint sum, step, nw;
        longint x [3];
        logic   done;
        done = 1'b0;
        case (m)
            MODE_EVAL: begin
                held_a = a;
                held_b = b;
                sum = longint'(syn_w[0]) * 256 + longint'(syn_w[1]) * longint'(held_a)
                    + longint'(syn_w[2]) * longint'(held_b);
                fire = (sum > 0);
            end
            MODE_LEARN: begin
                if (tries_left != 0) tries_left = tries_left - 16'd1;
                if (mark > peak_mark) peak_mark = mark;
                if (!(mark > last_mark)) begin
                    x[0] = 256;
                    x[1] = longint'(held_a);
                    x[2] = longint'(held_b);
                    for (int k = 0; k < 3; k++) begin
                        step = x[k] * longint'(rate);
                        if (fire) step = -step;
                        nw = longint'(syn_w[k]) + step;
                        if (nw > W_MAX) begin
                            syn_w[k] = 32'sh7fffffff;
                            saturations++;
                        end else if (nw < W_MIN) begin
                            syn_w[k] = 32'sh80000000;
                            saturations++;
                        end else begin
                            syn_w[k] = nw[31:0];
                        end
                    end
                end
                last_mark = mark;
                if (tries_left == 0 && mark >= peak_mark) begin
                    tries_left = tries_per_round;
                    last_mark  = '0;
                    peak_mark  = '0;
                    done       = 1'b1;
                    rounds_done++;
                end
            end
            MODE_CLEAR: begin
                for (int k = 0; k < 3; k++) syn_w[k] = '0;
            end
            default: ;
        endcase
        r = '{fire, done, tries_left, peak_mark};
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch: %s", what);
    endtask

    task automatic add_item(input t_mode m, input logic signed [15:0] a,
                            input logic signed [15:0] b, input logic signed [31:0] mark,
                            input logic typed = 1'b0, input t_result want = '0);
        t_row row;
        row = '{1'b0, CFG_LEARN_FACTOR, 16'd0, m, a, b, mark, typed, want};
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input t_cfg_index idx, input logic [15:0] val);
        t_row row;
        row = '{1'b1, idx, val, MODE_NOP, 16'sd0, 16'sd0, 32'sd0, 1'b0, t_result'('0)};
        directed_rows.push_back(row);
    endtask

    // drop the last request before waiting, so it is not taken twice
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [15:0] val);
        drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_LEARN_FACTOR) begin
            rate = val;
        end else begin
            tries_per_round = val;
            tries_left      = val;
        end
        settings_used++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_request(input t_mode m, input logic signed [15:0] a,
                                input logic signed [15:0] b, input logic signed [31:0] mark,
                                input logic typed, input t_result want);
        int      gap;
        t_result r;
        gap = steady ? 0 : $urandom_range(0, 14);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = m;
        i_s_tdata  = {mark, b, a};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        neuron_step(m, a, b, mark, r);
        pending_results.push_back(typed ? want : r);
        if (m != MODE_NOP) requests_sent++;
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2, 3:    return 16'($urandom_range(0, 1023)) - 16'sd512;
            default: return 16'($urandom);
        endcase
    endfunction

    // marks wander around the last one so both better and worse marks show up
    function automatic logic signed [31:0] pick_mark();
        case ($urandom_range(0, 9))
            0:       score = 32'sh80000000;
            1:       score = 32'sh7fffffff;
            2:       score = int'($urandom);
            3:       ;
            default: score = score + int'($urandom_range(0, 200)) - 100;
        endcase
        return score;
    endfunction

    // result side: random stall per result, then check against the oldest expectation
    initial begin : result_side
        int      stall;
        t_result want;
        logic    got_fire, got_done;
        logic [15:0] got_rem;
        logic signed [31:0] got_best;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 14);
            @(negedge i_clk);
            if (stall > 0) begin
                i_m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
            results_seen++;
            got_fire = o_m_tdata[0];
            got_rem  = o_m_tdata[16:1];
            got_best = o_m_tdata[48:17];
            got_done = o_m_tlast;
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with none pending", results_seen));
            end else begin
                want = pending_results.pop_front();
                if (got_fire !== want.fire)
                    flag_mismatch($sformatf("result %0d neuron_out got %0b want %0b",
                                            results_seen, got_fire, want.fire));
                if (got_done !== want.done)
                    flag_mismatch($sformatf("result %0d round_done got %0b want %0b",
                                            results_seen, got_done, want.done));
                if (got_rem !== want.remaining)
                    flag_mismatch($sformatf("result %0d attempts_remaining got %0d want %0d",
                                            results_seen, got_rem, want.remaining));
                if (got_best !== want.best)
                    flag_mismatch($sformatf("result %0d best_mark got %0d want %0d",
                                            results_seen, got_best, want.best));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready === 1'b1) ||
            (o_m_tvalid === 1'b1 && i_m_tready) || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_row        row;
        t_mode       m;
        logic [15:0] f, n;
        int          phase, target;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = MODE_EVAL;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_LEARN_FACTOR;
        i_cfg_data  = '0;
        for (int k = 0; k < 3; k++) syn_w[k] = '0;
        held_a = '0; held_b = '0; fire = 1'b0;
        last_mark = '0; peak_mark = '0;
        tries_left = '0; tries_per_round = '0; rate = '0;
        steady = 1'b0;
        score = 0;
        mismatches = 0; results_seen = 0; requests_sent = 0;
        rounds_done = 0; saturations = 0; settings_used = 0; idle_cycles = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values: factor 0, counter 0, so every learn with a good mark ends a round
        add_item(MODE_NOP,   16'sd0, 16'sd0, 32'sd0, 1'b1, '{1'b0, 1'b0, 16'd0, 32'sd0});
        add_item(MODE_EVAL,  16'sd0, 16'sd0, 32'sd0, 1'b1, '{1'b0, 1'b0, 16'd0, 32'sd0});
        add_item(MODE_LEARN, 16'sd0, 16'sd0, 32'sd0, 1'b1, '{1'b0, 1'b1, 16'd0, 32'sd0});
        add_item(MODE_LEARN, 16'sd0, 16'sd0, -32'sd5, 1'b1, '{1'b0, 1'b0, 16'd0, 32'sd0});
        add_item(MODE_LEARN, 16'sd0, 16'sd0, 32'sh7fffffff, 1'b1,
                 '{1'b0, 1'b1, 16'd0, 32'sd0});
        add_cfg(CFG_LEARN_FACTOR, 16'hffff);
        add_cfg(CFG_ATTEMPTS, 16'd3);
        add_item(MODE_EVAL, 16'sh7fff, 16'sh8000, 32'sd0, 1'b1, '{1'b0, 1'b0, 16'd3, 32'sd0});
        // two bad marks at full factor drive a and b weights into saturation
        add_item(MODE_LEARN, 16'sd0, 16'sd0, 32'sd0);
        add_item(MODE_LEARN, 16'sd0, 16'sd0, -32'sd1);
        add_item(MODE_EVAL, 16'sh7fff, 16'sd0, 32'sd0);
        add_item(MODE_EVAL, 16'sh8000, 16'sh7fff, 32'sd0);
        add_item(MODE_LEARN, 16'sd0, 16'sd0, 32'sd100);
        add_item(MODE_CLEAR, 16'sh7fff, 16'sh7fff, 32'sh7fffffff);
        add_item(MODE_EVAL, 16'sh7fff, 16'sh7fff, 32'sd0, 1'b1, '{1'b0, 1'b0, 16'd3, 32'sd0});
        add_item(MODE_NOP, 16'sh8000, 16'sh7fff, 32'sh80000000);
        add_cfg(CFG_ATTEMPTS, 16'hffff);
        add_cfg(CFG_LEARN_FACTOR, 16'd1);
        add_item(MODE_LEARN, 16'sd0, 16'sd0, 32'sh80000000);
        add_item(MODE_LEARN, 16'sd0, 16'sd0, 32'sh80000000);
        add_item(MODE_EVAL, -16'sd1, -16'sd1, 32'sd0);
        add_item(MODE_LEARN, 16'sd0, 16'sd0, 32'sd0);
        add_item(MODE_EVAL, 16'sh8000, 16'sh8000, 32'sd0);
        add_item(MODE_LEARN, 16'sd0, 16'sd0, 32'sh7fffffff);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg)
                write_register(row.reg_idx, row.reg_val);
            else
                send_request(row.mode, row.a, row.b, row.mark, row.typed, row.want);
        end
        drain();

        // random phases: mostly evaluate/learn trials, some noise, new settings each phase
        phase = 0;
        while (requests_sent < REQUESTS) begin
            case (phase)
                0: begin f = 16'hffff; n = 16'd0; end
                1: begin f = 16'd0; n = 16'hffff; end
                2: begin f = 16'd1; n = 16'd1; end
                default: begin
                    case ($urandom_range(0, 3))
                        0: f = 16'($urandom);
                        1: f = 16'($urandom_range(1, 255));
                        2: f = 16'hffff;
                        default: f = 16'($urandom_range(256, 4095));
                    endcase
                    n = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 20))
                                                    : 16'($urandom_range(1, 6));
                end
            endcase
            steady = (phase % 4 == 3);
            if (phase % 2 == 0) begin
                write_register(CFG_LEARN_FACTOR, f);
                write_register(CFG_ATTEMPTS, n);
            end else begin
                write_register(CFG_ATTEMPTS, n);
                write_register(CFG_LEARN_FACTOR, f);
            end
            target = requests_sent + 160;
            while (requests_sent < target) begin
                if ($urandom_range(0, 4) != 0) begin
                    send_request(MODE_EVAL, pick_sample(), pick_sample(), int'($urandom),
                                 1'b0, '0);
                    send_request(MODE_LEARN, 16'($urandom), 16'($urandom), pick_mark(),
                                 1'b0, '0);
                end else begin
                    m = t_mode'($urandom_range(0, 3));
                    send_request(m, 16'($urandom), 16'($urandom), int'($urandom), 1'b0, '0);
                end
                if ($urandom_range(0, 199) == 0) drain();
            end
            phase++;
        end

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        drain();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("run: %0d requests, %0d results checked, %0d register writes",
                 requests_sent, results_seen, settings_used);
        $display("run: %0d rounds completed, %0d weight saturations, %0d mismatches",
                 rounds_done, saturations, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rdp_pkg.sv
hw/rtl/reward_driven_perceptron.sv
hw/rtl/rdp_checker.sv
test/reward_driven_perceptron_test.sv
